// ----- sv/assert_macros.svh -----
// Assertion macros shared by the kinematic point predictor RTL.
// Every macro samples on the rising edge of i_clk and is switched off while
// i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define KPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define KPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor package
// Widths, fill stage codes, lane operation codes and the control structs.
// ----------------------------------------------------------------------------
package kpp_pkg;

    localparam int POS_W  = 32;
    localparam int TS_W   = 32;
    localparam int VEL_W  = 48;
    localparam int ACC_W  = 64;
    localparam int KEEP_W = 17;
    localparam int SUM_W  = 44;
    localparam int TERM_W = 42;

    localparam logic [KEEP_W-1:0] ONE_Q16 = 17'h10000;

    // Iteration counts of the serial units (two bits per cycle).
    localparam int DIV_CYCLES = 33;
    localparam int MUL_CYCLES = 9;
    localparam int VT_CYCLES  = 16;
    localparam int AT_CYCLES  = 32;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_TWO   = 2'd2;
    localparam logic [1:0] ST_READY = 2'd3;

    typedef logic [3:0] t_op;

    localparam t_op OP_IDLE     = 4'd0;
    localparam t_op OP_SHIFT    = 4'd1;
    localparam t_op OP_VDIV_LD  = 4'd2;
    localparam t_op OP_ADIV_LD  = 4'd3;
    localparam t_op OP_DIV_STEP = 4'd4;
    localparam t_op OP_VSTORE   = 4'd5;
    localparam t_op OP_ASTORE   = 4'd6;
    localparam t_op OP_MUL_STEP = 4'd7;
    localparam t_op OP_VFIN     = 4'd8;
    localparam t_op OP_AFIN     = 4'd9;
    localparam t_op OP_VTERM_LD = 4'd10;
    localparam t_op OP_ATERM_LD = 4'd11;
    localparam t_op OP_TERM_STEP= 4'd12;
    localparam t_op OP_VTERM_FIN= 4'd13;
    localparam t_op OP_ATERM_FIN= 4'd14;

    typedef struct packed {
        t_op        op;
        logic [1:0] stage;
        logic [1:0] bits;
    } t_lane_cmd;

    typedef struct packed {
        logic       done;
        logic [1:0] stage;
    } t_ctrl_stat;

endpackage

// ----- sv/kpp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor channel interfaces
// Valid/ready channels for input items and for prediction results.
// ----------------------------------------------------------------------------
interface kpp_obs_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [31:0]        timestamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, mode, timestamp, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, mode, timestamp, pos_x, pos_y, pos_z, output ready);
endinterface

interface kpp_pred_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
    logic [1:0]         fill_level;

    modport source (output valid, pred_x, pred_y, pred_z, fill_level, input ready);
    modport sink   (input valid, pred_x, pred_y, pred_z, fill_level, output ready);
endinterface

// ----- sv/kpp_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor axis lane
// Holds one axis of history and runs the serial divider, blend multiplier
// and extrapolation multiplier for that axis.
// ----------------------------------------------------------------------------
module kpp_lane import kpp_pkg::*; (
    input  logic                     i_clk,
    input  t_lane_cmd                i_cmd,
    input  logic [TS_W-1:0]          i_dt,
    input  logic signed [POS_W-1:0]  i_pos,
    output logic signed [SUM_W-1:0]  o_sum
);

    localparam logic [65:0] CAP48_POS = (66'd1 << 47) - 66'd1;
    localparam logic [65:0] CAP48_NEG = 66'd1 << 47;
    localparam logic [65:0] CAP64_POS = (66'd1 << 63) - 66'd1;
    localparam logic [65:0] CAP64_NEG = 66'd1 << 63;
    localparam logic [75:0] TERM_CAP  = 76'd1 << 40;

    logic signed [POS_W-1:0] r_p0, r_p1;
    logic signed [VEL_W-1:0] r_v0, r_v1;
    logic signed [ACC_W-1:0] r_acc, r_tmp;
    logic [65:0]             r_dvd, r_quo;
    logic [32:0]             r_rem;
    logic                    r_neg;
    logic signed [64:0]      r_md;
    logic signed [82:0]      r_macc;
    logic [75:0]             r_tacc;
    logic                    r_tsat;
    logic [63:0]             r_tmag;
    logic                    r_tneg;
    logic signed [TERM_W-1:0] r_tv, r_ta;

    logic signed [32:0] w_pdiff;
    logic [32:0]        w_pmag;
    logic signed [48:0] w_vdiff;
    logic [48:0]        w_vmag;
    logic [65:0]        n_dvd, n_quo;
    logic [32:0]        n_rem;
    logic [65:0]        w_res48, w_res64;
    logic signed [VEL_W-1:0] w_raw48;
    logic signed [ACC_W-1:0] w_raw64;
    logic signed [82:0] n_macc, w_msh;
    logic [75:0]        n_tacc, w_tsh, w_tcap;
    logic               n_tsat;
    logic signed [TERM_W-1:0] w_term;
    logic [VEL_W-1:0]   w_vabs;
    logic [ACC_W-1:0]   w_aabs;

    assign w_pdiff = {r_p0[POS_W-1], r_p0} - {r_p1[POS_W-1], r_p1};
    assign w_pmag  = w_pdiff[32] ? (~w_pdiff + 33'd1) : w_pdiff;
    assign w_vdiff = {r_v0[VEL_W-1], r_v0} - {r_v1[VEL_W-1], r_v1};
    assign w_vmag  = w_vdiff[48] ? (~w_vdiff + 49'd1) : w_vdiff;
    assign w_vabs  = r_v0[VEL_W-1] ? (~r_v0 + 48'd1) : r_v0;
    assign w_aabs  = r_acc[ACC_W-1] ? (~r_acc + 64'd1) : r_acc;

    // Restoring divider, two quotient bits per cycle.
    always_comb begin
        logic [33:0] remx;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            remx  = {n_rem, n_dvd[65]};
            n_dvd = {n_dvd[64:0], 1'b0};
            if (remx >= {2'b00, i_dt}) begin
                remx  = remx - {2'b00, i_dt};
                n_quo = {n_quo[64:0], 1'b1};
            end else begin
                n_quo = {n_quo[64:0], 1'b0};
            end
            n_rem = remx[32:0];
        end
    end

    // Quotient clipped to the signed range of the destination.
    always_comb begin
        logic [65:0] cap48, cap64;
        cap48   = r_neg ? CAP48_NEG : CAP48_POS;
        cap64   = r_neg ? CAP64_NEG : CAP64_POS;
        w_res48 = (r_quo > cap48) ? cap48 : r_quo;
        w_res64 = (r_quo > cap64) ? cap64 : r_quo;
        w_raw48 = r_neg ? (~w_res48[47:0] + 48'd1) : w_res48[47:0];
        w_raw64 = r_neg ? (~w_res64[63:0] + 64'd1) : w_res64[63:0];
    end

    // Blend multiplier: difference times keep weight, MSB first.
    always_comb begin
        n_macc = r_macc;
        for (int i = 0; i < 2; i++) begin
            n_macc = (n_macc <<< 1) +
                     (i_cmd.bits[1-i] ? {{18{r_md[64]}}, r_md} : 83'sd0);
        end
    end
    assign w_msh = r_macc >>> 16;

    // Extrapolation multiplier on magnitudes; it sticks once past any cap.
    always_comb begin
        n_tacc = r_tacc;
        n_tsat = r_tsat;
        for (int i = 0; i < 2; i++) begin
            if (!n_tsat) begin
                n_tacc = {n_tacc[74:0], 1'b0} + (i_cmd.bits[1-i] ? {12'd0, r_tmag} : 76'd0);
                if (n_tacc[75] | n_tacc[74]) begin
                    n_tsat = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_tsh  = (i_cmd.op == OP_VTERM_FIN) ? (r_tacc >> 16) : (r_tacc >> 33);
        w_tcap = (r_tsat || (w_tsh > TERM_CAP)) ? TERM_CAP : w_tsh;
        w_term = r_tneg ? (~w_tcap[TERM_W-1:0] + 42'd1) : w_tcap[TERM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SHIFT: begin
                r_p1 <= r_p0;
                r_p0 <= i_pos;
            end
            OP_VDIV_LD: begin
                r_dvd <= {17'd0, w_pmag, 16'd0};
                r_neg <= w_pdiff[32];
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_ADIV_LD: begin
                r_dvd <= {1'b0, w_vmag, 16'd0};
                r_neg <= w_vdiff[48];
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            OP_VSTORE: begin
                if (i_cmd.stage == ST_ONE) begin
                    r_v0 <= w_raw48;
                end else if (i_cmd.stage == ST_TWO) begin
                    r_v1 <= r_v0;
                    r_v0 <= w_raw48;
                end else begin
                    r_tmp  <= {{16{w_raw48[VEL_W-1]}}, w_raw48};
                    r_md   <= {{17{r_v0[VEL_W-1]}}, r_v0} - {{17{w_raw48[VEL_W-1]}}, w_raw48};
                    r_macc <= '0;
                end
            end
            OP_ASTORE: begin
                if (i_cmd.stage == ST_TWO) begin
                    r_acc <= w_raw64;
                end else begin
                    r_tmp  <= w_raw64;
                    r_md   <= {r_acc[ACC_W-1], r_acc} - {w_raw64[ACC_W-1], w_raw64};
                    r_macc <= '0;
                end
            end
            OP_MUL_STEP: begin
                r_macc <= n_macc;
            end
            OP_VFIN: begin
                r_v1 <= r_v0;
                r_v0 <= r_tmp[VEL_W-1:0] + w_msh[VEL_W-1:0];
            end
            OP_AFIN: begin
                r_acc <= r_tmp + w_msh[ACC_W-1:0];
            end
            OP_VTERM_LD: begin
                r_tmag <= {16'd0, w_vabs};
                r_tneg <= r_v0[VEL_W-1];
                r_tacc <= '0;
                r_tsat <= 1'b0;
            end
            OP_ATERM_LD: begin
                r_tmag <= w_aabs;
                r_tneg <= r_acc[ACC_W-1];
                r_tacc <= '0;
                r_tsat <= 1'b0;
            end
            OP_TERM_STEP: begin
                r_tacc <= n_tacc;
                r_tsat <= n_tsat;
            end
            OP_VTERM_FIN: begin
                r_tv <= w_term;
            end
            OP_ATERM_FIN: begin
                r_ta <= w_term;
            end
            default: begin
            end
        endcase
    end

    // Unsaturated extrapolated coordinate for the merge stage.
    always_comb begin
        o_sum = '0;
        if (i_cmd.stage != ST_EMPTY) begin
            o_sum = {{(SUM_W-POS_W){r_p0[POS_W-1]}}, r_p0};
        end
        if (i_cmd.stage == ST_TWO || i_cmd.stage == ST_READY) begin
            o_sum = o_sum + {{(SUM_W-TERM_W){r_tv[TERM_W-1]}}, r_tv};
        end
        if (i_cmd.stage == ST_READY) begin
            o_sum = o_sum + {{(SUM_W-TERM_W){r_ta[TERM_W-1]}}, r_ta};
        end
    end

endmodule

// ----- sv/kpp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor sequencer
// Accepts transactions, keeps fill stage, time and keep weights, and steps
// the three axis lanes through division, blending and extrapolation.
// ----------------------------------------------------------------------------
module kpp_ctrl import kpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_mode,
    input  logic [TS_W-1:0]   i_timestamp,
    output logic              o_ready,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [KEEP_W-1:0] i_cfg_data,
    input  logic              i_res_ready,
    output t_lane_cmd         o_cmd,
    output logic [TS_W-1:0]   o_dt,
    output t_ctrl_stat        o_stat
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_VLD   = 5'd1;
    localparam logic [4:0] S_VDIV  = 5'd2;
    localparam logic [4:0] S_VST   = 5'd3;
    localparam logic [4:0] S_VMUL  = 5'd4;
    localparam logic [4:0] S_VFIN  = 5'd5;
    localparam logic [4:0] S_ALD   = 5'd6;
    localparam logic [4:0] S_ADIV  = 5'd7;
    localparam logic [4:0] S_AST   = 5'd8;
    localparam logic [4:0] S_AMUL  = 5'd9;
    localparam logic [4:0] S_AFIN  = 5'd10;
    localparam logic [4:0] S_VTLD  = 5'd11;
    localparam logic [4:0] S_VTERM = 5'd12;
    localparam logic [4:0] S_VTFIN = 5'd13;
    localparam logic [4:0] S_ATLD  = 5'd14;
    localparam logic [4:0] S_ATERM = 5'd15;
    localparam logic [4:0] S_ATFIN = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic REG_VKEEP = 1'b0;
    localparam logic REG_AKEEP = 1'b1;

    logic [4:0]        r_state, n_state;
    logic [5:0]        r_cnt;
    logic [1:0]        r_stage;
    logic [TS_W-1:0]   r_t0, r_dt;
    logic [KEEP_W-1:0] r_vkeep, r_akeep;
    logic [17:0]       r_kbits;
    logic [63:0]       r_tbits, r_sq, n_sq;
    logic [31:0]       r_sqb;
    logic              w_accept;
    logic [TS_W-1:0]   w_dt_raw;
    logic [KEEP_W-1:0] w_vk_clamp, w_ak_clamp;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_dt_raw   = i_timestamp - r_t0;
    assign w_vk_clamp = (r_vkeep > ONE_Q16) ? ONE_Q16 : r_vkeep;
    assign w_ak_clamp = (r_akeep > ONE_Q16) ? ONE_Q16 : r_akeep;
    assign o_dt       = r_dt;
    assign o_stat     = '{done: (r_state == S_OUT), stage: r_stage};

    // Squared interval for the quadratic term, built during the linear term.
    always_comb begin
        n_sq = r_sq;
        for (int i = 0; i < 2; i++) begin
            n_sq = {n_sq[62:0], 1'b0} + (r_sqb[31-i] ? {32'd0, r_dt} : 64'd0);
        end
    end

    always_comb begin
        o_cmd = '{op: OP_IDLE, stage: r_stage, bits: 2'b00};
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !i_mode) begin
                    o_cmd.op = OP_SHIFT;
                    n_state  = (r_stage == ST_EMPTY) ? S_IDLE : S_VLD;
                end else if (w_accept) begin
                    n_state = (r_stage == ST_TWO || r_stage == ST_READY) ? S_VTLD : S_OUT;
                end
            end
            S_VLD: begin
                o_cmd.op = OP_VDIV_LD;
                n_state  = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == 6'(DIV_CYCLES - 1)) n_state = S_VST;
            end
            S_VST: begin
                o_cmd.op = OP_VSTORE;
                if (r_stage == ST_ONE) n_state = S_IDLE;
                else if (r_stage == ST_TWO) n_state = S_ALD;
                else n_state = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.op   = OP_MUL_STEP;
                o_cmd.bits = r_kbits[17:16];
                if (r_cnt == 6'(MUL_CYCLES - 1)) n_state = S_VFIN;
            end
            S_VFIN: begin
                o_cmd.op = OP_VFIN;
                n_state  = S_ALD;
            end
            S_ALD: begin
                o_cmd.op = OP_ADIV_LD;
                n_state  = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == 6'(DIV_CYCLES - 1)) n_state = S_AST;
            end
            S_AST: begin
                o_cmd.op = OP_ASTORE;
                n_state  = (r_stage == ST_TWO) ? S_IDLE : S_AMUL;
            end
            S_AMUL: begin
                o_cmd.op   = OP_MUL_STEP;
                o_cmd.bits = r_kbits[17:16];
                if (r_cnt == 6'(MUL_CYCLES - 1)) n_state = S_AFIN;
            end
            S_AFIN: begin
                o_cmd.op = OP_AFIN;
                n_state  = S_IDLE;
            end
            S_VTLD: begin
                o_cmd.op = OP_VTERM_LD;
                n_state  = S_VTERM;
            end
            S_VTERM: begin
                o_cmd.op   = OP_TERM_STEP;
                o_cmd.bits = r_tbits[63:62];
                if (r_cnt == 6'(VT_CYCLES - 1)) n_state = S_VTFIN;
            end
            S_VTFIN: begin
                o_cmd.op = OP_VTERM_FIN;
                n_state  = (r_stage == ST_READY) ? S_ATLD : S_OUT;
            end
            S_ATLD: begin
                o_cmd.op = OP_ATERM_LD;
                n_state  = S_ATERM;
            end
            S_ATERM: begin
                o_cmd.op   = OP_TERM_STEP;
                o_cmd.bits = r_tbits[63:62];
                if (r_cnt == 6'(AT_CYCLES - 1)) n_state = S_ATFIN;
            end
            S_ATFIN: begin
                o_cmd.op = OP_ATERM_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= ST_EMPTY;
            r_t0    <= '0;
            r_vkeep <= '0;
            r_akeep <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 6'd0 : r_cnt + 6'd1;
            if (i_cfg_we && i_cfg_idx == REG_VKEEP) r_vkeep <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_AKEEP) r_akeep <= i_cfg_data;
            if (w_accept && !i_mode) begin
                r_t0 <= i_timestamp;
                if (r_stage == ST_EMPTY) r_stage <= ST_ONE;
            end
            if (r_state == S_VST && r_stage == ST_ONE) r_stage <= ST_TWO;
            if (r_state == S_AST && r_stage == ST_TWO) r_stage <= ST_READY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt <= (!i_mode && w_dt_raw == '0) ? 32'd1 : w_dt_raw;
        end
        case (r_state)
            S_VST:   r_kbits <= {1'b0, w_vk_clamp};
            S_AST:   r_kbits <= {1'b0, w_ak_clamp};
            S_VMUL, S_AMUL: r_kbits <= {r_kbits[15:0], 2'b00};
            S_VTLD: begin
                r_tbits <= {r_dt, 32'd0};
                r_sq    <= '0;
                r_sqb   <= r_dt;
            end
            S_VTERM: begin
                r_tbits <= {r_tbits[61:0], 2'b00};
                r_sq    <= n_sq;
                r_sqb   <= {r_sqb[29:0], 2'b00};
            end
            S_ATLD:  r_tbits <= r_sq;
            S_ATERM: r_tbits <= {r_tbits[61:0], 2'b00};
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/kpp_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor merge stage
// Saturates the three lane sums to Q16.16 and holds the result transaction
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module kpp_merge import kpp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [SUM_W-1:0] i_sum_x,
    input  logic signed [SUM_W-1:0] i_sum_y,
    input  logic signed [SUM_W-1:0] i_sum_z,
    input  logic [1:0]              i_stage,
    output logic                    o_ready,
    kpp_pred_if.source              o_pred
);

    localparam logic signed [SUM_W-1:0] SAT_HI = (44'sd1 <<< 31) - 44'sd1;
    localparam logic signed [SUM_W-1:0] SAT_LO = -(44'sd1 <<< 31);

    function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[POS_W-1:0];
    endfunction

    logic                    r_valid;
    logic signed [POS_W-1:0] r_x, r_y, r_z;
    logic [1:0]              r_fill;

    assign o_ready = !r_valid || o_pred.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_pred.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x    <= sat32(i_sum_x);
            r_y    <= sat32(i_sum_y);
            r_z    <= sat32(i_sum_z);
            r_fill <= i_stage;
        end
    end

    assign o_pred.valid      = r_valid;
    assign o_pred.pred_x     = r_x;
    assign o_pred.pred_y     = r_y;
    assign o_pred.pred_z     = r_z;
    assign o_pred.fill_level = r_fill;

endmodule

// ----- sv/kinematic_point_predictor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor, top level
// Constant-acceleration extrapolator of a 3D point from timestamped samples.
// ----------------------------------------------------------------------------
// Usage:
// i_obs carries one transaction per item. Mode 0 stores an observed point
// and updates the per-tick velocity and acceleration; it returns nothing.
// Mode 1 asks for the position at the given timestamp; one transaction on
// o_pred follows with the Q16.16 point and the fill level.
// An observe is taken at once while empty; on the second point it runs
// the velocity division, on the third also the acceleration division,
// and once ready both divisions and both blends, so the serial dividers
// and blend multipliers set the cost. A predict goes straight to the
// output register before two points are held, runs the linear serial
// multiplier with two points and also the quadratic one once ready.
// i_obs.ready is high only while the sequencer is idle. The result sits in
// an output register, so a stalled receiver holds the result there and the
// next input transaction is still taken; a second result waits in the
// sequencer until the register frees up. Reset (synchronous, active low)
// empties the history and zeroes both keep weights. The keep weights must
// be written through i_cfg_* only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kinematic_point_predictor_top import kpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kpp_obs_if.sink           i_obs,
    kpp_pred_if.source        o_pred,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [KEEP_W-1:0] i_cfg_data
);

    t_lane_cmd                w_cmd;
    t_ctrl_stat               w_stat;
    logic [TS_W-1:0]          w_dt;
    logic                     w_res_ready;
    logic signed [POS_W-1:0]  w_pos [3];
    logic signed [SUM_W-1:0]  w_sum [3];

    assign w_pos[0] = i_obs.pos_x;
    assign w_pos[1] = i_obs.pos_y;
    assign w_pos[2] = i_obs.pos_z;

    // The sequencer owns the fill stage, time base and keep weights.
    kpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_obs.valid),
        .i_mode      (i_obs.mode),
        .i_timestamp (i_obs.timestamp),
        .o_ready     (i_obs.ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_res_ready (w_res_ready),
        .o_cmd       (w_cmd),
        .o_dt        (w_dt),
        .o_stat      (w_stat)
    );

    // One lane per axis, all driven in lockstep by the same command.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        kpp_lane u_lane (
            .i_clk (i_clk),
            .i_cmd (w_cmd),
            .i_dt  (w_dt),
            .i_pos (w_pos[g]),
            .o_sum (w_sum[g])
        );
    end

    kpp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_stat.done && w_res_ready),
        .i_sum_x (w_sum[0]),
        .i_sum_y (w_sum[1]),
        .i_sum_z (w_sum[2]),
        .i_stage (w_stat.stage),
        .o_ready (w_res_ready),
        .o_pred  (o_pred)
    );

    // A pending result and a free input side never coexist.
    `KPP_ASSERT_NOW(a_ready_not_done, i_obs.ready, !w_stat.done, "input ready while result pending")
    // An observation never produces a result on the following cycle.
    `KPP_ASSERT_NEXT(a_obs_no_result, i_obs.valid && i_obs.ready && !i_obs.mode, !w_stat.done, "observe produced a result")
    // Once a point is held the history never empties again outside reset.
    `KPP_ASSERT_NEXT(a_stage_keeps, w_stat.stage != ST_EMPTY, w_stat.stage != ST_EMPTY, "fill stage fell back to empty")

endmodule

// ----- verif/kinematic_point_predictor_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kinematic point predictor testbench
// Drives observe and predict transactions through the valid/ready channels,
// predicts every result with a bit-exact model of the extrapolator and checks
// each prediction field by field. The run walks through several smoothing
// weights and several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

typedef struct {
    bit               mode;
    bit [31:0]        stamp;
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
} kpp_sample_t;

typedef struct {
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
    bit [1:0]         fill;
} kpp_point_t;

class motion_scoreboard;
    bit [16:0]  vel_keep;
    bit [16:0]  acc_keep;
    bit [1:0]   fill;
    longint     pts[9];
    bit [31:0]  stamps[3];
    longint     vel[6];
    longint     acc[3];
    kpp_point_t point_q[$];
    int         errors;
    int         matched;
    int         observed;

    function void clear();
        fill = kpp_pkg::ST_EMPTY;
        vel_keep = 0;
        acc_keep = 0;
        foreach (pts[i]) pts[i] = 0;
        foreach (stamps[i]) stamps[i] = 0;
        foreach (vel[i]) vel[i] = 0;
        foreach (acc[i]) acc[i] = 0;
    endfunction

    function int pending();
        return point_q.size();
    endfunction

    // (num << 16) / d, truncated toward zero, saturated to w signed bits.
    function longint rate_of(longint num, bit [31:0] d, int w);
        logic signed [127:0] n;
        logic [127:0]        mag;
        logic [127:0]        lim;
        logic [127:0]        q;
        n   = num;
        mag = (n < 0) ? -n : n;
        lim = (128'd1 << (w - 1)) - ((n < 0) ? 128'd0 : 128'd1);
        q   = (mag << 16) / d;
        if (q > lim)
            q = lim;
        return (n < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // Weighted mix of old and new by a Q1.16 keep weight, with a floor on the product.
    function longint smooth(longint old_v, longint raw_v, bit [16:0] keep);
        logic signed [127:0] k;
        logic signed [127:0] o;
        logic signed [127:0] r;
        logic signed [127:0] s;
        k = (keep > 17'h10000) ? 128'sd65536 : 128'(keep);
        o = old_v;
        r = raw_v;
        s = o * k + r * (128'sd65536 - k);
        s = s >>> 16;
        return longint'(s[63:0]);
    endfunction

    // Magnitude of coef times t, shifted right, capped at 2^40, sign restored.
    function longint drift(longint coef, bit [63:0] t, int sh);
        bit [63:0]    a;
        logic [127:0] p;
        a = (coef < 0) ? 64'd0 - 64'(coef) : 64'(coef);
        p = {64'd0, a} * {64'd0, t};
        p = p >> sh;
        if (p > (128'd1 << 40))
            p = 128'd1 << 40;
        return (coef < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void set_keep(bit idx, bit [16:0] val);
        if (idx == 1'b0)
            vel_keep = val;
        else
            acc_keep = val;
    endfunction

    function void note_input(kpp_sample_t s);
        bit [31:0]  dt;
        bit [63:0]  dt2;
        longint     r;
        longint     raw;
        longint     vprev;
        longint     anew;
        longint     sat[3];
        kpp_point_t p;
        dt = s.stamp - stamps[0];
        if (s.mode == 1'b1) begin
            dt2 = 64'(dt) * 64'(dt);
            for (int i = 0; i < 3; i++) begin
                r = 0;
                if (fill >= kpp_pkg::ST_ONE)
                    r = pts[i];
                if (fill >= kpp_pkg::ST_TWO)
                    r += drift(vel[i], 64'(dt), 16);
                if (fill == kpp_pkg::ST_READY)
                    r += drift(acc[i], dt2, 33);
                if (r > 64'sd2147483647)
                    r = 64'sd2147483647;
                if (r < -64'sd2147483648)
                    r = -64'sd2147483648;
                sat[i] = r;
            end
            p.x = sat[0][31:0];
            p.y = sat[1][31:0];
            p.z = sat[2][31:0];
            p.fill = fill;
            point_q.push_back(p);
            return;
        end
        observed++;
        if (dt == 0)
            dt = 1;
        for (int i = 0; i < 3; i++) begin
            pts[6 + i] = pts[3 + i];
            pts[3 + i] = pts[i];
        end
        pts[0] = longint'(s.x);
        pts[1] = longint'(s.y);
        pts[2] = longint'(s.z);
        stamps[2] = stamps[1];
        stamps[1] = stamps[0];
        stamps[0] = s.stamp;
        if (fill == kpp_pkg::ST_EMPTY) begin
            fill = kpp_pkg::ST_ONE;
            return;
        end
        for (int i = 0; i < 3; i++) begin
            raw = rate_of(pts[i] - pts[3 + i], dt, 48);
            if (fill == kpp_pkg::ST_ONE) begin
                vel[i] = raw;
            end else if (fill == kpp_pkg::ST_TWO) begin
                vel[3 + i] = vel[i];
                vel[i] = raw;
                acc[i] = rate_of(raw - vel[3 + i], dt, 64);
            end else begin
                vprev = vel[i];
                vel[3 + i] = vprev;
                vel[i] = smooth(vprev, raw, vel_keep);
                anew = rate_of(vel[i] - vprev, dt, 64);
                acc[i] = smooth(acc[i], anew, acc_keep);
            end
        end
        if (fill != kpp_pkg::ST_READY)
            fill++;
    endfunction

    function void check_result(kpp_point_t got);
        kpp_point_t want;
        if (point_q.size() == 0) begin
            $display("%0t: unexpected prediction x=%h y=%h z=%h fill=%0d",
                     $time, got.x, got.y, got.z, got.fill);
            errors++;
            return;
        end
        want = point_q.pop_front();
        if (got.x !== want.x) begin
            $display("%0t: pred_x expected %h actual %h", $time, want.x, got.x);
            errors++;
        end
        if (got.y !== want.y) begin
            $display("%0t: pred_y expected %h actual %h", $time, want.y, got.y);
            errors++;
        end
        if (got.z !== want.z) begin
            $display("%0t: pred_z expected %h actual %h", $time, want.z, got.z);
            errors++;
        end
        if (got.fill !== want.fill) begin
            $display("%0t: fill_level expected %0d actual %0d", $time, want.fill, got.fill);
            errors++;
        end
        matched++;
    endfunction
endclass

module kinematic_point_predictor_top_test;
    import kpp_pkg::*;

    localparam bit MODE_OBSERVE = 1'b0;
    localparam bit MODE_PREDICT = 1'b1;
    localparam bit CFG_VEL_KEEP = 1'b0;
    localparam bit CFG_ACC_KEEP = 1'b1;
    // An observe that returns nothing may still be in the sequencer after it
    // is taken; this margin covers it with room to spare.
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [16:0] i_cfg_data;

    kpp_obs_if  obs_ch ();
    kpp_pred_if pred_ch ();

    kinematic_point_predictor_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_obs      (obs_ch),
        .o_pred     (pred_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    motion_scoreboard motion_sb;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_left;
    bit [31:0]   track_t;
    int          track_p[3];
    int          track_v[3];

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Every signal into the block is known from time zero.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_VEL_KEEP;
        i_cfg_data       = '0;
        obs_ch.valid     = 1'b0;
        obs_ch.mode      = MODE_OBSERVE;
        obs_ch.timestamp = '0;
        obs_ch.pos_x     = '0;
        obs_ch.pos_y     = '0;
        obs_ch.pos_z     = '0;
        pred_ch.ready    = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_req         = 1'b0;
        hold_left        = 0;
        motion_sb        = new();
        motion_sb.clear();
    end

    // Generous overall limit; the slowest legal run finishes well inside it.
    initial begin
        #20_000_000;
        $display("Timeout with %0d predictions outstanding", motion_sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when the stimulus asks for
    // one so that the result register stays full and the block backs up.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pred_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                pred_ch.ready <= 1'b0;
            end else begin
                pred_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Result monitor: a transaction is taken on the rising edge.
    always @(posedge i_clk) begin
        kpp_point_t got;
        if (i_rst_n && pred_ch.valid && pred_ch.ready) begin
            got.x = pred_ch.pred_x;
            got.y = pred_ch.pred_y;
            got.z = pred_ch.pred_z;
            got.fill = pred_ch.fill_level;
            motion_sb.check_result(got);
        end
    end

    // Offers one item, with random idle cycles first; returns at a falling
    // edge after the transaction has been accepted.
    task automatic send_sample(input kpp_sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            obs_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        obs_ch.valid     <= 1'b1;
        obs_ch.mode      <= s.mode;
        obs_ch.timestamp <= s.stamp;
        obs_ch.pos_x     <= s.x;
        obs_ch.pos_y     <= s.y;
        obs_ch.pos_z     <= s.z;
        do
            @(posedge i_clk);
        while (!obs_ch.ready);
        motion_sb.note_input(s);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input bit m, input bit [31:0] ts,
                               input bit [31:0] x, input bit [31:0] y, input bit [31:0] z);
        kpp_sample_t s;
        s.mode = m;
        s.stamp = ts;
        s.x = x;
        s.y = y;
        s.z = z;
        send_sample(s);
    endtask

    // Waits until every prediction is back, then lets a trailing observe
    // finish inside the block.
    task automatic drain();
        obs_ch.valid <= 1'b0;
        while (motion_sb.pending() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_keeps(input bit [16:0] vk, input bit [16:0] ak);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_VEL_KEEP;
        i_cfg_data <= vk;
        motion_sb.set_keep(CFG_VEL_KEEP, vk);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ACC_KEEP;
        i_cfg_data <= ak;
        motion_sb.set_keep(CFG_ACC_KEEP, ak);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Observes along a smooth track with random content, about as many predictions
    // ahead of it, and a share of items with every field fully random.
    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_fields(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 55) begin
            track_t += $urandom_range(0, 2000);
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 9) == 0)
                    track_v[i] = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
                track_p[i] += track_v[i] * int'($urandom_range(0, 3));
            end
            send_fields(MODE_OBSERVE, track_t, track_p[0], track_p[1], track_p[2]);
        end else begin
            send_fields(MODE_PREDICT, track_t + $urandom_range(0, 5000),
                        $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int rounds;
        bit [16:0] vk;
        bit [16:0] ak;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with both weights at zero: every fill stage, zero
        // and backward intervals, extreme coordinates and saturation.
        write_keeps(17'd0, 17'd0);
        send_fields(MODE_PREDICT, 32'd5, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fields(MODE_OBSERVE, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_fields(MODE_PREDICT, 32'd50, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_OBSERVE, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_fields(MODE_PREDICT, 32'd200, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_PREDICT, 32'd0, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_OBSERVE, 32'd101, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_fields(MODE_PREDICT, 32'd101, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_PREDICT, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_OBSERVE, 32'h10, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        send_fields(MODE_PREDICT, 32'h20, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_OBSERVE, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(MODE_PREDICT, 32'd0, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_OBSERVE, 32'hFFFF_FFF3, 32'h7FFF_0000, 32'h7FFF_0000, 32'h8001_0000);
        send_fields(MODE_PREDICT, 32'hFFFF_FFF6, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_PREDICT, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        track_t = 32'hFFFF_FFF3;
        for (int i = 0; i < 3; i++) begin
            track_p[i] = 0;
            track_v[i] = 1 << 14;
        end

        // Random part in four phases, each with its own weights and its
        // own idle and stall pattern.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    vk = 17'd0;
                    ak = 17'd0;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    vk = ONE_Q16;
                    ak = ONE_Q16;
                    send_idle_pct = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    vk = 17'h1FFFF;
                    ak = 17'h1FFFF;
                    send_idle_pct = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    vk = 17'($urandom_range(0, 65536));
                    ak = 17'($urandom_range(0, 65536));
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase
            write_keeps(vk, ak);
            rounds = 0;
            while (rounds < 410) begin
                if (rounds == 100 && phase == 1)
                    hold_req = 1'b1;
                if (rounds == 200 && phase == 2)
                    drain();
                if (rounds == 300 && phase == 3)
                    write_keeps(17'($urandom), 17'($urandom));
                send_random();
                rounds++;
            end
        end

        drain();
        $display("Covered %0d observe and %0d predict transactions over several weights,",
                 motion_sb.observed, motion_sb.matched);
        $display("including zero and backward intervals, saturation and long output stalls.");
        if (motion_sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/kpp_pkg.sv
sv/kpp_if.sv
sv/kpp_lane.sv
sv/kpp_ctrl.sv
sv/kpp_merge.sv
sv/kinematic_point_predictor_top.sv
verif/kinematic_point_predictor_top_test.sv
